FILE: rtl/core/priority_bitmap_task_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define PBTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define PBTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBTS_ASSERT_IMP(lbl, ante, cons, msg)
`define PBTS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/pbts_pkg.sv
package pbts_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 8;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH + 1) : 1;
    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int ADDR_W = LVL_W + IDX_W;
    localparam int DATA_W = 16;

    // Commands
    localparam logic CMD_ENQ  = 1'b0;
    localparam logic CMD_DISP = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL_TASK = 3'd1,
        ST_BAD_PRIO  = 3'd2,
        ST_FULL      = 3'd3,
        ST_NONE      = 3'd4
    } t_status;

    // Access to the task store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Decision for the accepted item
    typedef struct packed {
        t_status    status;
        logic       pop;
        logic [3:0] lvl;
    } t_dec;

endpackage

FILE: rtl/core/pbts_store.sv
module pbts_store (
    input  logic                          i_clk,
    input  pbts_pkg::t_mem_req            i_req,
    output logic [pbts_pkg::DATA_W-1:0]   o_rdata
);
    import pbts_pkg::*;

    localparam int MEM_DEPTH = NUM_LEVELS * (2 ** IDX_W);

    // {task_id, event} per entry, row = {level, slot}
    logic [DATA_W-1:0] r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

FILE: rtl/core/pbts_ctrl.sv
`include "priority_bitmap_task_scheduler_macros.svh"

module pbts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_cmd,
    input  logic [3:0]          i_prio,
    input  logic [7:0]          i_task_id,
    input  logic [7:0]          i_event_req,
    input  logic [3:0]          i_running_level,
    output pbts_pkg::t_mem_req  o_mem,
    output pbts_pkg::t_dec      o_dec
);
    import pbts_pkg::*;

    // Per-level queue control
    logic [NUM_LEVELS-1:0] r_mask, n_mask;
    logic [IDX_W-1:0]      r_head  [NUM_LEVELS];
    logic [IDX_W-1:0]      n_head  [NUM_LEVELS];
    logic [CNT_W-1:0]      r_count [NUM_LEVELS];
    logic [CNT_W-1:0]      n_count [NUM_LEVELS];

    logic [LVL_W-1:0]      w_enq_q;
    logic                  w_prio_ok;
    logic [3:0]            w_top_lvl;
    logic [LVL_W-1:0]      w_top_q;
    logic [LVL_W-1:0]      w_q;
    logic [IDX_W-1:0]      w_head;
    logic [CNT_W-1:0]      w_count;
    logic                  w_full;
    logic [IDX_W:0]        w_sum;
    logic [IDX_W-1:0]      w_tail;
    logic [IDX_W-1:0]      w_head_inc;
    logic [NUM_LEVELS-1:0] w_nonempty;

    // Enqueue level decode
    assign w_prio_ok = (i_prio != 4'd0) && (i_prio <= 4'(NUM_LEVELS));
    assign w_enq_q   = LVL_W'(i_prio - 4'd1);

    // Highest ready level, 0 when none
    always_comb begin
        w_top_lvl = 4'd0;
        w_top_q   = '0;
        for (int b = 0; b < NUM_LEVELS; b++) begin
            if (r_mask[b]) begin
                w_top_lvl = 4'(b + 1);
                w_top_q   = LVL_W'(b);
            end
        end
    end

    // Selected level's pointers
    assign w_q     = (i_cmd == CMD_ENQ) ? w_enq_q : w_top_q;
    assign w_head  = r_head[w_q];
    assign w_count = r_count[w_q];
    assign w_full  = (w_count == CNT_W'(QUEUE_DEPTH));

    // Tail slot: head + count folded once into the ring
    assign w_sum  = (IDX_W+1)'(w_head) + (IDX_W+1)'(w_count);
    assign w_tail = (w_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                  ? IDX_W'(w_sum - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(w_sum);
    assign w_head_inc = (w_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : w_head + 1'b1;

    // Decision and next state
    always_comb begin
        n_mask  = r_mask;
        n_head  = r_head;
        n_count = r_count;
        o_mem   = '0;
        o_dec   = '{status: ST_OK, pop: 1'b0, lvl: 4'd0};
        o_mem.wdata = {i_task_id, i_event_req};
        o_mem.waddr = {w_q, w_tail};
        o_mem.raddr = {w_q, w_head};
        if (i_cmd == CMD_ENQ) begin
            priority if (i_task_id == 8'd0) begin
                o_dec.status = ST_NULL_TASK;
            end else if (!w_prio_ok) begin
                o_dec.status = ST_BAD_PRIO;
            end else if (w_full) begin
                o_dec.status = ST_FULL;
            end else begin
                if (i_accept) begin
                    o_mem.we      = 1'b1;
                    n_count[w_q]  = w_count + 1'b1;
                    n_mask[w_q]   = 1'b1;
                end
            end
        end else begin
            priority if ((w_top_lvl == 4'd0) || (w_top_lvl <= i_running_level)) begin
                o_dec.status = ST_NONE;
            end else if (w_count == '0) begin
                // stale ready bit: drop it
                o_dec.status = ST_NONE;
                if (i_accept) begin
                    n_mask[w_q] = 1'b0;
                end
            end else begin
                o_dec.pop = 1'b1;
                o_dec.lvl = w_top_lvl;
                if (i_accept) begin
                    o_mem.re     = 1'b1;
                    n_head[w_q]  = w_head_inc;
                    n_count[w_q] = w_count - 1'b1;
                    if (w_count == CNT_W'(1)) begin
                        n_mask[w_q] = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            r_mask  <= n_mask;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            w_nonempty[l] = (r_count[l] != '0);
        end
    end

    `PBTS_ASSERT_IMP(a_mask_tracks_count, 1'b1, r_mask == w_nonempty, "ready mask vs fill")
    `PBTS_ASSERT_IMP(a_no_write_when_full, o_mem.we, !w_full, "write into a full queue")
    `PBTS_ASSERT_NXT(a_enq_sets_ready, o_mem.we, r_mask[$past(w_q)], "level not ready")

endmodule

FILE: rtl/core/priority_bitmap_task_scheduler.sv
// Channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------------
// input    | i_in_valid / o_in_stall     | i_cmd i_prio i_task_id i_event_req i_running_level
// output   | o_out_valid / i_out_stall   | o_status o_out_task_id o_out_event o_out_prio
//
// One item at a time: accept, then the task store's registered read in S_READ,
// then the result register, which holds the result in S_HOLD while the output is stalled.
// Reset (synchronous, active low) empties every level; the store itself is not cleared.
// While a result is stalled, no new item is accepted.
`include "priority_bitmap_task_scheduler_macros.svh"

module priority_bitmap_task_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [3:0] i_prio,
    input  logic [7:0] i_task_id,
    input  logic [7:0] i_event_req,
    input  logic [3:0] i_running_level,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_out_task_id,
    output logic [7:0] o_out_event,
    output logic [3:0] o_out_prio
);
    import pbts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    t_state             r_state;
    t_dec               r_dec;
    t_mem_req           w_mem;
    t_dec               w_dec;
    logic [DATA_W-1:0]  w_rdata;
    logic               w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    pbts_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_cmd           (i_cmd),
        .i_prio          (i_prio),
        .i_task_id       (i_task_id),
        .i_event_req     (i_event_req),
        .i_running_level (i_running_level),
        .o_mem           (w_mem),
        .o_dec           (w_dec)
    );

    pbts_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_dec   <= w_dec;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    o_status      <= r_dec.status;
                    o_out_task_id <= r_dec.pop ? w_rdata[15:8] : 8'd0;
                    o_out_event   <= r_dec.pop ? w_rdata[7:0] : 8'd0;
                    o_out_prio    <= r_dec.lvl;
                    o_out_valid   <= 1'b1;
                    r_state       <= S_HOLD;
                end
                S_HOLD: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `PBTS_ASSERT_IMP(a_valid_in_hold, 1'b1, o_out_valid == (r_state == S_HOLD), "valid out of step")
    `PBTS_ASSERT_NXT(a_accept_reads, w_accept, r_state == S_READ, "accepted item not in flight")
    `PBTS_ASSERT_IMP(a_pop_has_level, o_out_valid && (o_out_task_id != 8'd0), (o_out_prio != 4'd0) && (o_status == ST_OK), "dispatch result without level")

endmodule

FILE: test/scheduler_result_checker.sv
`timescale 1ns / 100ps

module scheduler_result_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_cmd,
    input  logic [3:0] i_prio,
    input  logic [7:0] i_task_id,
    input  logic [7:0] i_event_req,
    input  logic [3:0] i_running_level,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_status,
    input  logic [7:0] i_out_task_id,
    input  logic [7:0] i_out_event,
    input  logic [3:0] i_out_prio,
    output int         o_pending,
    output int         o_errors
);
    import pbts_pkg::*;

    typedef struct {
        t_status    status;
        logic [7:0] task_id;
        logic [7:0] event_code;
        logic [3:0] level;
    } sched_result_t;

    typedef struct packed {
        logic [7:0] task_id;
        logic [7:0] event_code;
    } task_entry_t;

    // Shadow copy of the scheduler state
    task_entry_t           entry_store [NUM_LEVELS][QUEUE_DEPTH];
    logic [NUM_LEVELS-1:0] ready_levels;
    int unsigned           head_idx [NUM_LEVELS];
    int unsigned           fill_cnt [NUM_LEVELS];

    sched_result_t awaited_results [$];
    int            awaited_cnt;
    int            mismatches;

    assign o_pending = awaited_cnt;
    assign o_errors  = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Applies one item to the shadow state and returns the result it must produce
    function automatic sched_result_t predict_result(
        input logic       cmd,
        input logic [3:0] prio,
        input logic [7:0] task_id,
        input logic [7:0] event_code,
        input logic [3:0] run_level
    );
        sched_result_t res;
        task_entry_t   popped;
        int            q;
        int            top;
        int            tail;
        res.status     = ST_OK;
        res.task_id    = '0;
        res.event_code = '0;
        res.level      = '0;
        if (cmd == CMD_ENQ) begin
            // null handle wins over bad level, bad level over full queue
            if (task_id == 8'd0) begin
                res.status = ST_NULL_TASK;
            end else if (prio < 1 || prio > NUM_LEVELS) begin
                res.status = ST_BAD_PRIO;
            end else begin
                q = int'(prio) - 1;
                if (fill_cnt[q] >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    tail = (head_idx[q] + fill_cnt[q]) % QUEUE_DEPTH;
                    entry_store[q][tail] = {task_id, event_code};
                    fill_cnt[q]++;
                    ready_levels[q] = 1'b1;
                end
            end
        end else begin
            // highest ready level must be strictly above the running one
            top = 0;
            for (int b = 0; b < NUM_LEVELS; b++) begin
                if (ready_levels[b]) top = b + 1;
            end
            if (top == 0 || top <= int'(run_level) || fill_cnt[top-1] == 0) begin
                res.status = ST_NONE;
                if (top != 0 && top > int'(run_level)) ready_levels[top-1] = 1'b0;
            end else begin
                q = top - 1;
                popped = entry_store[q][head_idx[q]];
                head_idx[q] = (head_idx[q] + 1) % QUEUE_DEPTH;
                fill_cnt[q]--;
                if (fill_cnt[q] == 0) ready_levels[q] = 1'b0;
                res.task_id    = popped.task_id;
                res.event_code = popped.event_code;
                res.level      = 4'(top);
            end
        end
        return res;
    endfunction

    // Check results first, then queue the prediction for a new item
    always @(posedge i_clk) begin : monitor
        sched_result_t want;
        if (!i_rst_n) begin
            ready_levels = '0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head_idx[l] = 0;
                fill_cnt[l] = 0;
            end
            awaited_results.delete();
            awaited_cnt <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no item pending", i_status, -1);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status != want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_out_task_id != want.task_id)
                        report_mismatch("task id", i_out_task_id, want.task_id);
                    if (i_out_event != want.event_code)
                        report_mismatch("event", i_out_event, want.event_code);
                    if (i_out_prio != want.level)
                        report_mismatch("level", i_out_prio, want.level);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(predict_result(i_cmd, i_prio, i_task_id,
                                                         i_event_req, i_running_level));
            end
            awaited_cnt <= awaited_results.size();
        end
    end

endmodule

FILE: test/priority_bitmap_task_scheduler_tb.sv
`timescale 1ns / 100ps

module priority_bitmap_task_scheduler_tb;
    import pbts_pkg::*;

    localparam int NUM_ITEMS   = 950;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    typedef enum int { MIX_BALANCED, MIX_FILL, MIX_DRAIN } mix_t;
    typedef enum int { RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC } rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [3:0] prio;
    logic [7:0] task_id;
    logic [7:0] event_req;
    logic [3:0] running_level;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [7:0] out_task_id;
    logic [7:0] out_event;
    logic [3:0] out_prio;

    int pending;
    int errors;
    bit hold_req;

    priority_bitmap_task_scheduler dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_prio          (prio),
        .i_task_id       (task_id),
        .i_event_req     (event_req),
        .i_running_level (running_level),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_out_task_id   (out_task_id),
        .o_out_event     (out_event),
        .o_out_prio      (out_prio)
    );

    scheduler_result_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_prio          (prio),
        .i_task_id       (task_id),
        .i_event_req     (event_req),
        .i_running_level (running_level),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (status),
        .i_out_task_id   (out_task_id),
        .i_out_event     (out_event),
        .i_out_prio      (out_prio),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one item and hold it until the block takes it
    task automatic offer_item(input logic c, input logic [3:0] p, input logic [7:0] t,
                              input logic [7:0] e, input logic [3:0] r);
        @(negedge clk);
        in_valid      <= 1'b1;
        cmd           <= c;
        prio          <= p;
        task_id       <= t;
        event_req     <= e;
        running_level <= r;
        do @(posedge clk); while (in_stall);
    endtask

    // Idle cycles on the input, with junk on the payload
    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid      <= 1'b0;
            cmd           <= 1'($urandom_range(0, 1));
            prio          <= 4'($urandom_range(0, 15));
            task_id       <= 8'($urandom_range(0, 255));
            event_req     <= 8'($urandom_range(0, 255));
            running_level <= 4'($urandom_range(0, 15));
        end
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: stall pattern changes in phases; a requested hold overrides it once
    initial begin : receiver
        rx_mode_t mode;
        int       hold_left;
        int       phase_left;
        int       step;
        bit       hold_done;
        out_stall  = 1'b0;
        mode       = RX_FLOW;
        hold_left  = 0;
        phase_left = 0;
        step       = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (phase_left == 0) begin
                mode       = rx_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            step++;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    RX_FLOW:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:  out_stall <= ((step % 5) < 2);
                endcase
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        mix_t       mix;
        int         burst_left;
        logic       c;
        logic [3:0] p;
        logic [7:0] t;
        logic [3:0] r;
        in_valid      = 1'b0;
        cmd           = CMD_ENQ;
        prio          = '0;
        task_id       = '0;
        event_req     = '0;
        running_level = '0;
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        burst_left    = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty dispatch, check order, level range, running level
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd0);
        offer_item(CMD_ENQ, 4'd5, 8'h00, 8'h12, 4'd0);
        offer_item(CMD_ENQ, 4'd0, 8'h00, 8'h00, 4'd0);
        offer_item(CMD_ENQ, 4'd0, 8'h33, 8'h44, 4'd0);
        offer_item(CMD_ENQ, 4'd9, 8'h55, 8'h66, 4'd0);
        offer_item(CMD_ENQ, 4'd15, 8'hFF, 8'hFF, 4'd15);
        offer_item(CMD_ENQ, 4'd1, 8'h01, 8'h00, 4'd15);
        offer_item(CMD_ENQ, 4'd8, 8'hFF, 8'hFF, 4'd0);
        offer_item(CMD_ENQ, 4'd8, 8'h80, 8'h01, 4'd0);
        offer_item(CMD_ENQ, 4'd4, 8'hA5, 8'h5A, 4'd0);
        offer_item(CMD_DISP, 4'd15, 8'hFF, 8'hFF, 4'd15);
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd8);
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd7);
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd0);
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd4);
        offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd3);
        offer_item(CMD_ENQ, 4'd2, 8'h7E, 8'h81, 4'd0);
        offer_item(CMD_ENQ, 4'd3, 8'h3C, 8'hC3, 4'd0);
        offer_item(CMD_ENQ, 4'd6, 8'h0F, 8'hF0, 4'd0);
        offer_item(CMD_ENQ, 4'd7, 8'hF0, 8'h0F, 4'd0);
        // drains levels 7, 6, 3, 2, 1 in order, then finds nothing
        repeat (6) offer_item(CMD_DISP, 4'd0, 8'h00, 8'h00, 4'd0);

        // Random: phases of mixed traffic, queue filling and draining
        for (int k = 0; k < NUM_ITEMS; k++) begin
            mix = mix_t'((k / 100) % 3);
            if (k == 150) hold_req = 1'b1;
            if (k == 520) wait_all_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                // no sender gaps in one stretch
                if (k < 650 || k >= 750) idle_sender($urandom_range(0, 8));
            end
            burst_left--;
            case (mix)
                MIX_FILL:  c = ($urandom_range(0, 99) < 15) ? CMD_DISP : CMD_ENQ;
                MIX_DRAIN: c = ($urandom_range(0, 99) < 85) ? CMD_DISP : CMD_ENQ;
                default:   c = $urandom_range(0, 1) ? CMD_DISP : CMD_ENQ;
            endcase
            if ($urandom_range(0, 9) == 0) p = 4'($urandom_range(0, 15));
            else if (mix == MIX_FILL) p = 4'($urandom_range(1, 2));
            else p = 4'($urandom_range(1, NUM_LEVELS));
            t = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            if ($urandom_range(0, 4) == 0) r = 4'($urandom_range(0, 15));
            else if (mix == MIX_DRAIN) r = 4'd0;
            else r = 4'($urandom_range(0, NUM_LEVELS));
            offer_item(c, p, t, 8'($urandom_range(0, 255)), r);
        end

        wait_all_results();
        repeat (10) @(posedge clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
